### rtl/pts_pkg.sv
// shared types, codes and widths for the priority task scheduler
package pts_pkg;

    localparam int PTS_TASK_SLOTS = 8;

    localparam int OP_W       = 3;
    localparam int PRIO_W     = 8;
    localparam int DELAY_W    = 32;
    localparam int SLOT_IN_W  = 3;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 48;

    localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
    localparam logic [OP_W-1:0] OP_DELAY    = 3'd1;
    localparam logic [OP_W-1:0] OP_SUSPEND  = 3'd2;
    localparam logic [OP_W-1:0] OP_ACTIVATE = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd4;

    localparam logic [1:0] TS_READY     = 2'd0;
    localparam logic [1:0] TS_RUNNING   = 2'd1;
    localparam logic [1:0] TS_WAITING   = 2'd2;
    localparam logic [1:0] TS_SUSPENDED = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_SLOT = 2'd2;

    typedef struct packed {
        logic [1:0]         tstate;
        logic [DELAY_W-1:0] delay;
    } dyn_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic              idle;
    } attr_t;

endpackage

### rtl/priority_task_scheduler.sv
// create and unknown ops go from accept through exec to the response register; the others also
// scan the created slots and decide before the response; one request is handled at a time
// the dispatch scan reads one slot per cycle through the single table read port
// a new request is taken while the previous response still waits on m_tready
// reset clears slot count, current slot, tick count and handshakes; table contents undefined
module priority_task_scheduler import pts_pkg::*; #(
    parameter int TASK_SLOTS = PTS_TASK_SLOTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // task_priority_in, start_ready, marks_idle, delay_ticks, target_slot
    input  logic [S_DATA_W-1:0] s_tdata,
    // op
    input  logic [OP_W-1:0]     s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status, new_handle, running_slot, switch_request, tick_total
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int SW   = $clog2(TASK_SLOTS);
    localparam int CW   = $clog2(TASK_SLOTS + 1);
    localparam int CMPW = (CW > SLOT_IN_W) ? CW : SLOT_IN_W;
    localparam int WX   = (SW > SLOT_IN_W) ? SW : SLOT_IN_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]           state_reg;
    logic [OP_W-1:0]      op_reg;
    logic [PRIO_W-1:0]    prio_reg;
    logic                 start_ready_reg;
    logic                 marks_idle_reg;
    logic [DELAY_W-1:0]   delay_reg;
    logic [SLOT_IN_W-1:0] target_reg;

    logic [CW-1:0]        count_reg;
    logic [SW-1:0]        current_reg;
    logic [SW-1:0]        pick_reg;
    logic [DELAY_W-1:0]   ticks_reg;

    logic [SW-1:0]        scan_idx_reg;
    logic                 best_found_reg;
    logic [PRIO_W-1:0]    best_pri_reg;
    logic [SW-1:0]        best_idx_reg;
    logic                 idle_found_reg;
    logic [SW-1:0]        idle_idx_reg;

    logic                 fwd_valid_reg;
    logic [SW-1:0]        fwd_addr_reg;
    logic [1:0]           fwd_state_reg;

    logic [STATUS_W-1:0]  status_reg;
    logic [SW-1:0]        handle_reg;
    logic                 sw_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    logic [SW-1:0]        rd_addr;
    logic                 attr_we;
    logic [SW-1:0]        attr_waddr;
    attr_t                attr_wdata;
    attr_t                attr_rdata;
    logic                 dyn_we;
    logic [SW-1:0]        dyn_waddr;
    dyn_t                 dyn_wdata;
    dyn_t                 dyn_rdata;

    logic                 table_full;
    logic                 tgt_ok;
    logic [SW-1:0]        tgt_addr;
    logic [CMPW-1:0]      tgt_ext;
    logic [CMPW-1:0]      cnt_ext;
    dyn_t                 slot_dyn;
    logic [DELAY_W-1:0]   dec_delay;
    logic                 tick_upd;
    logic [1:0]           new_state;
    logic                 eligible;
    logic                 take;
    logic                 scan_last;
    logic [SW-1:0]        pick;
    logic [WX-1:0]        cur_x;
    logic [WX-1:0]        handle_x;

    pts_slot_table #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_table (
        .aclk       (aclk),
        .rd_addr    (rd_addr),
        .attr_we    (attr_we),
        .attr_waddr (attr_waddr),
        .attr_wdata (attr_wdata),
        .attr_rdata (attr_rdata),
        .dyn_we     (dyn_we),
        .dyn_waddr  (dyn_waddr),
        .dyn_wdata  (dyn_wdata),
        .dyn_rdata  (dyn_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign table_full = !(count_reg < CW'(TASK_SLOTS));
    assign tgt_ext    = CMPW'(target_reg);
    assign cnt_ext    = CMPW'(count_reg);
    assign tgt_ok     = tgt_ext < cnt_ext;
    assign tgt_addr   = tgt_ext[SW-1:0];

    // forward the state written in the exec cycle to the scan read of the same slot
    always_comb begin
        slot_dyn = dyn_rdata;
        if (fwd_valid_reg && (fwd_addr_reg == scan_idx_reg)) begin
            slot_dyn.tstate = fwd_state_reg;
        end
    end

    assign dec_delay = slot_dyn.delay - DELAY_W'(1);
    assign tick_upd  = (op_reg == OP_TICK) && (slot_dyn.tstate == TS_WAITING);
    assign new_state = tick_upd ? ((dec_delay == '0) ? TS_READY : TS_WAITING)
                                : slot_dyn.tstate;
    assign eligible  = (new_state == TS_READY) || (new_state == TS_RUNNING);
    assign take      = eligible && (attr_rdata.prio >= best_pri_reg);
    assign scan_last = (CW'(scan_idx_reg) == (count_reg - CW'(1)));
    assign pick      = best_found_reg ? best_idx_reg :
                       idle_found_reg ? idle_idx_reg : pick_reg;

    assign cur_x    = WX'(current_reg);
    assign handle_x = WX'(handle_reg);

    always_comb begin
        rd_addr    = '0;
        attr_we    = 1'b0;
        attr_waddr = count_reg[SW-1:0];
        attr_wdata = '{prio: prio_reg, idle: marks_idle_reg};
        dyn_we     = 1'b0;
        dyn_waddr  = current_reg;
        dyn_wdata  = '{tstate: TS_READY, delay: delay_reg};
        unique case (state_reg)
            S_EXEC: begin
                unique case (op_reg)
                    OP_CREATE: begin
                        attr_we   = !table_full;
                        dyn_we    = !table_full;
                        dyn_waddr = count_reg[SW-1:0];
                        dyn_wdata = '{tstate: start_ready_reg ? TS_READY : TS_SUSPENDED,
                                      delay: '0};
                    end
                    OP_DELAY: begin
                        dyn_we    = 1'b1;
                        dyn_wdata = '{tstate: TS_WAITING, delay: delay_reg};
                    end
                    OP_SUSPEND: begin
                        dyn_we    = 1'b1;
                        dyn_wdata = '{tstate: TS_SUSPENDED, delay: delay_reg};
                    end
                    OP_ACTIVATE: begin
                        dyn_we    = tgt_ok;
                        dyn_waddr = tgt_addr;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                rd_addr   = scan_idx_reg + SW'(1);
                dyn_we    = tick_upd;
                dyn_waddr = scan_idx_reg;
                dyn_wdata = '{tstate: new_state, delay: dec_delay};
            end
            S_DECIDE: begin
                dyn_we    = (pick != current_reg);
                dyn_waddr = pick;
                dyn_wdata = '{tstate: TS_RUNNING, delay: delay_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            current_reg   <= '0;
            pick_reg      <= '0;
            ticks_reg     <= '0;
            fwd_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (m_tready && (state_reg != S_RESP)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg          <= s_tuser;
                        prio_reg        <= s_tdata[7:0];
                        start_ready_reg <= s_tdata[8];
                        marks_idle_reg  <= s_tdata[9];
                        delay_reg       <= s_tdata[41:10];
                        target_reg      <= s_tdata[44:42];
                        state_reg       <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    sw_reg         <= 1'b0;
                    scan_idx_reg   <= '0;
                    best_found_reg <= 1'b0;
                    best_pri_reg   <= '0;
                    idle_found_reg <= 1'b0;
                    fwd_valid_reg  <= dyn_we;
                    fwd_addr_reg   <= dyn_waddr;
                    fwd_state_reg  <= dyn_wdata.tstate;
                    unique case (op_reg)
                        OP_CREATE: begin
                            if (table_full) begin
                                status_reg <= STAT_FULL;
                                handle_reg <= '0;
                            end else begin
                                status_reg <= STAT_OK;
                                count_reg  <= count_reg + CW'(1);
                                handle_reg <= count_reg[SW-1:0];
                            end
                            state_reg <= S_RESP;
                        end
                        OP_DELAY, OP_SUSPEND, OP_ACTIVATE, OP_TICK: begin
                            status_reg <= ((op_reg == OP_ACTIVATE) && !tgt_ok) ?
                                          STAT_BAD_SLOT : STAT_OK;
                            handle_reg <= '0;
                            if (op_reg == OP_TICK) begin
                                ticks_reg <= ticks_reg + DELAY_W'(1);
                            end
                            state_reg <= (count_reg == '0) ? S_DECIDE : S_SCAN;
                        end
                        default: begin
                            status_reg <= STAT_OK;
                            handle_reg <= '0;
                            state_reg  <= S_RESP;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (attr_rdata.idle) begin
                        idle_found_reg <= 1'b1;
                        idle_idx_reg   <= scan_idx_reg;
                    end
                    if (take) begin
                        best_found_reg <= 1'b1;
                        best_pri_reg   <= attr_rdata.prio;
                        best_idx_reg   <= scan_idx_reg;
                    end
                    if (scan_last) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + SW'(1);
                    end
                end
                S_DECIDE: begin
                    pick_reg <= pick;
                    if (pick != current_reg) begin
                        current_reg <= pick;
                        sw_reg      <= 1'b1;
                    end
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {7'b0, ticks_reg, sw_reg, cur_x[2:0],
                                         handle_x[2:0], status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TASK_SLOTS))
        else $error("slot count above table size");

    a_current_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (CW'(current_reg) < count_reg))
        else $error("current slot outside created slots");

    a_scan_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (CW'(scan_idx_reg) < count_reg))
        else $error("scan index outside created slots");

    a_ticks_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (ticks_reg != $past(ticks_reg))) |->
            ($past(state_reg) == S_EXEC) && ($past(op_reg) == OP_TICK))
        else $error("tick count moved without a tick request");

endmodule

### rtl/pts_slot_table.sv
// task slot table: attribute memory and state/delay memory, registered reads
module pts_slot_table import pts_pkg::*; #(
    parameter int TASK_SLOTS = PTS_TASK_SLOTS,
    localparam int SW = $clog2(TASK_SLOTS)
) (
    input  logic          aclk,
    input  logic [SW-1:0] rd_addr,
    input  logic          attr_we,
    input  logic [SW-1:0] attr_waddr,
    input  attr_t         attr_wdata,
    output attr_t         attr_rdata,
    input  logic          dyn_we,
    input  logic [SW-1:0] dyn_waddr,
    input  dyn_t          dyn_wdata,
    output dyn_t          dyn_rdata
);

    attr_t attr_mem [TASK_SLOTS];
    dyn_t  dyn_mem  [TASK_SLOTS];
    attr_t attr_rdata_reg;
    dyn_t  dyn_rdata_reg;

    always_ff @(posedge aclk) begin
        if (attr_we) begin
            attr_mem[attr_waddr] <= attr_wdata;
        end
        attr_rdata_reg <= attr_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (dyn_we) begin
            dyn_mem[dyn_waddr] <= dyn_wdata;
        end
        dyn_rdata_reg <= dyn_mem[rd_addr];
    end

    assign attr_rdata = attr_rdata_reg;
    assign dyn_rdata  = dyn_rdata_reg;

endmodule
